FILE: hw/rtl/qrbm_pkg.sv
package qrbm_pkg;

  localparam int DATA_W = 8;
  localparam int SYM_BYTES_W = 13;
  localparam int VERSION_W = 6;
  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_VERSION = 2'd1;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // highest version with 8-bit byte counts
  localparam logic [VERSION_W-1:0] SHORT_COUNT_MAX_VER = 6'd9;

  // output buffer
  localparam int OBUF_AW = 2;
  localparam int OBUF_DEPTH = 1 << OBUF_AW;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic [1:0] kind;
    logic is_last;
  } item_t;

  // results of one parsed byte: at most one data byte, then at most one status
  typedef struct packed {
    logic data_vld;
    logic [DATA_W-1:0] data_byte;
    logic end_vld;
    logic [1:0] end_kind;
  } step_res_t;

endpackage

FILE: hw/rtl/qrbm_parse.sv
module qrbm_parse #(
  parameter int MAX_BYTES = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic [qrbm_pkg::DATA_W-1:0] data_byte,
  input  logic [qrbm_pkg::SYM_BYTES_W-1:0] symbol_bytes,
  input  logic ver_big,
  output qrbm_pkg::step_res_t res
);
  import qrbm_pkg::*;

  localparam int OCW = $clog2(MAX_BYTES + 1);
  localparam int AVW = SYM_BYTES_W + 1;

  localparam logic [3:0] MODE_TERM = 4'd0;
  localparam logic [3:0] MODE_APPEND = 4'd3;
  localparam logic [3:0] MODE_BYTE = 4'd4;
  localparam logic [3:0] MODE_FNC1_FIRST = 4'd5;
  localparam logic [3:0] MODE_FNC1_SECOND = 4'd9;

  typedef enum logic [1:0] {PH_MODE, PH_COUNT, PH_DATA, PH_SKIP} phase_t;

  // fields are 4, 8 or 16 bits long, so all boundaries fall on nibbles
  typedef struct packed {
    phase_t phase;
    logic [2:0] fnib;
    logic [15:0] fval;
    logic [15:0] chars;
    logic fin;
  } pst_t;

  typedef struct packed {
    pst_t st;
    logic data_vld;
    logic [DATA_W-1:0] data_byte;
    logic end_vld;
    logic [1:0] end_kind;
  } nres_t;

  function automatic nres_t do_start(input nres_t r, input phase_t ph, input logic [2:0] n);
    nres_t o;
    o = r;
    o.st.phase = ph;
    o.st.fnib = n;
    o.st.fval = '0;
    return o;
  endfunction

  function automatic nres_t do_finish(input nres_t r, input logic [1:0] k);
    nres_t o;
    o = r;
    o.end_vld = 1'b1;
    o.end_kind = k;
    o.st.fin = 1'b1;
    return o;
  endfunction

  // avail counts nibbles left in the symbol after this one
  function automatic nres_t do_enter(input nres_t r, input logic [AVW-1:0] avail);
    nres_t o;
    if (avail == '0) o = do_finish(r, KIND_OK);
    else o = do_start(r, PH_MODE, 3'd1);
    return o;
  endfunction

  function automatic nres_t nib_step(input pst_t s, input logic [3:0] nib,
                                     input logic [AVW-1:0] avail, input logic big);
    nres_t r;
    logic [15:0] v;
    logic [15:0] cm1;
    logic [2:0] cbn;
    r.st = s;
    r.data_vld = 1'b0;
    r.data_byte = '0;
    r.end_vld = 1'b0;
    r.end_kind = KIND_OK;
    v = {s.fval[11:0], nib};
    cm1 = s.chars - 16'd1;
    cbn = big ? 3'd4 : 3'd2;
    if (!s.fin) begin
      r.st.fval = v;
      r.st.fnib = s.fnib - 3'd1;
      if (s.fnib == 3'd1) begin
        unique case (s.phase)
          PH_MODE: begin
            if (v[3:0] == MODE_TERM) r = do_finish(r, KIND_OK);
            else if (v[3:0] == MODE_FNC1_FIRST || v[3:0] == MODE_FNC1_SECOND)
              r = do_enter(r, avail);
            else if (v[3:0] == MODE_APPEND) begin
              if (avail < AVW'(4)) r = do_finish(r, KIND_FAIL);
              else r = do_start(r, PH_SKIP, 3'd4);
            end else if (v[3:0] == MODE_BYTE) begin
              if (avail < AVW'(cbn)) r = do_finish(r, KIND_FAIL);
              else r = do_start(r, PH_COUNT, cbn);
            end else r = do_finish(r, KIND_FAIL);
          end
          PH_COUNT: begin
            r.st.chars = v;
            if (v == '0) r = do_enter(r, avail);
            // count of bytes needs twice as many nibbles
            else if ({v, 1'b0} > 17'(avail)) r = do_finish(r, KIND_FAIL);
            else r = do_start(r, PH_DATA, 3'd2);
          end
          PH_DATA: begin
            r.data_vld = 1'b1;
            r.data_byte = v[DATA_W-1:0];
            r.st.chars = cm1;
            if (cm1 == '0) r = do_enter(r, avail);
            else r = do_start(r, PH_DATA, 3'd2);
          end
          PH_SKIP: r = do_enter(r, avail);
          default: r = do_finish(r, KIND_FAIL);
        endcase
      end
    end
    return r;
  endfunction

  pst_t st_r;
  logic [SYM_BYTES_W-1:0] ibl_r;
  logic [OCW-1:0] ocount_r;
  logic fresh_r;

  pst_t cur;
  logic [SYM_BYTES_W-1:0] ibl_cur;
  logic [SYM_BYTES_W-1:0] ibl_dec;
  logic [OCW-1:0] ocount_cur;
  nres_t n1;
  nres_t n2;
  logic last_byte;
  logic tail_fail;
  logic below_cap;
  logic data_any;

  always_comb begin
    if (fresh_r) begin
      cur.phase = PH_MODE;
      cur.fnib = 3'd1;
      cur.fval = '0;
      cur.chars = '0;
      cur.fin = 1'b0;
      ibl_cur = (symbol_bytes == '0) ? SYM_BYTES_W'(1) : symbol_bytes;
      ocount_cur = '0;
    end else begin
      cur = st_r;
      ibl_cur = ibl_r;
      ocount_cur = ocount_r;
    end
    ibl_dec = ibl_cur - SYM_BYTES_W'(1);
    n1 = nib_step(cur, data_byte[7:4], {ibl_dec, 1'b1}, ver_big);
    n2 = nib_step(n1.st, data_byte[3:0], {ibl_dec, 1'b0}, ver_big);
    last_byte = (ibl_dec == '0);
    tail_fail = last_byte && !n2.st.fin;
    below_cap = (ocount_cur < OCW'(MAX_BYTES));
    data_any = n1.data_vld || n2.data_vld;
  end

  always_comb begin
    res.data_vld = step && data_any && below_cap;
    res.data_byte = n1.data_vld ? n1.data_byte : n2.data_byte;
    res.end_vld = step && (n1.end_vld || n2.end_vld || tail_fail);
    if (n1.end_vld) res.end_kind = n1.end_kind;
    else if (n2.end_vld) res.end_kind = n2.end_kind;
    else res.end_kind = KIND_FAIL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= PH_MODE;
      st_r.fnib <= 3'd1;
      st_r.fval <= '0;
      st_r.chars <= '0;
      st_r.fin <= 1'b0;
      ibl_r <= SYM_BYTES_W'(1);
      ocount_r <= '0;
      fresh_r <= 1'b1;
    end else if (step) begin
      st_r <= n2.st;
      ibl_r <= ibl_dec;
      ocount_r <= ocount_cur + OCW'(data_any && below_cap);
      fresh_r <= last_byte;
    end
  end

endmodule

FILE: hw/rtl/qrbm_out_buf.sv
module qrbm_out_buf (
  input  logic clk,
  input  logic rst_n,
  input  qrbm_pkg::step_res_t res,
  output logic room2,
  output logic out_valid,
  input  logic out_stall,
  output qrbm_pkg::item_t head
);
  import qrbm_pkg::*;

  item_t mem [OBUF_DEPTH];
  logic [OBUF_AW-1:0] wr_ptr_r;
  logic [OBUF_AW-1:0] rd_ptr_r;
  logic [OBUF_AW:0] cnt_r;

  item_t item0;
  item_t item1;
  logic [1:0] push_n;
  logic pop;

  always_comb begin
    item0.data_byte = res.data_vld ? res.data_byte : '0;
    item0.kind = res.data_vld ? KIND_DATA : res.end_kind;
    item0.is_last = !res.data_vld;
    item1.data_byte = '0;
    item1.kind = res.end_kind;
    item1.is_last = 1'b1;
    push_n = {1'b0, res.data_vld} + {1'b0, res.end_vld};
  end

  assign out_valid = (cnt_r != '0);
  assign pop = out_valid && !out_stall;
  assign head = mem[rd_ptr_r];
  assign room2 = (cnt_r <= (OBUF_AW + 1)'(OBUF_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr_r] <= item0;
    if (push_n == 2'd2) mem[wr_ptr_r + OBUF_AW'(1)] <= item1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OBUF_AW'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + OBUF_AW'(1);
      cnt_r <= cnt_r + (OBUF_AW + 1)'(push_n) - (OBUF_AW + 1)'(pop);
    end
  end

endmodule

FILE: hw/rtl/qr_byte_mode_segment_parser.sv
// channel  direction  handshake                 payload
// in_      input      in_valid / in_stall       in_data_byte
// out_     output     out_valid / out_stall     out_byte, out_kind, out_is_last
// cfg_     input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one codeword byte per cycle while in_stall is low; a byte that yields a data byte and an end status
// needs two output transfers, so the output buffer sets the rate then
// a byte passes through the input register, then parse logic into the output buffer
// rst_n is synchronous; the first byte after reset starts a symbol with the
// registers as they are at that moment
// in_stall rises while the input register holds a byte and the output buffer
// has fewer than two free slots
module qr_byte_mode_segment_parser #(
  parameter int MAX_BYTES = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [qrbm_pkg::DATA_W-1:0] in_data_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic [qrbm_pkg::DATA_W-1:0] out_byte,
  output logic [1:0] out_kind,
  output logic out_is_last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [qrbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qrbm_pkg::SYM_BYTES_W-1:0] cfg_data
);
  import qrbm_pkg::*;

  logic in_vld_r;
  logic [DATA_W-1:0] in_byte_r;
  logic [SYM_BYTES_W-1:0] symbol_bytes_r;
  logic [VERSION_W-1:0] symbol_version_r;

  logic room2;
  logic step;
  logic in_take;
  step_res_t res;
  item_t head;

  assign cfg_ready = 1'b1;
  assign step = in_vld_r && room2;
  assign in_stall = in_vld_r && !room2;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_byte_r <= in_data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_bytes_r <= SYM_BYTES_W'(1);
      symbol_version_r <= VERSION_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SYMBOL_BYTES: symbol_bytes_r <= cfg_data;
        CFG_SYMBOL_VERSION: symbol_version_r <= cfg_data[VERSION_W-1:0];
        default: ;
      endcase
    end
  end

  qrbm_parse #(
    .MAX_BYTES(MAX_BYTES)
  ) u_parse (
    .clk(clk),
    .rst_n(rst_n),
    .step(step),
    .data_byte(in_byte_r),
    .symbol_bytes(symbol_bytes_r),
    .ver_big(symbol_version_r > SHORT_COUNT_MAX_VER),
    .res(res)
  );

  qrbm_out_buf u_out_buf (
    .clk(clk),
    .rst_n(rst_n),
    .res(res),
    .room2(room2),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head(head)
  );

  assign out_byte = head.data_byte;
  assign out_kind = head.kind;
  assign out_is_last = head.is_last;

endmodule

FILE: verif/qr_byte_mode_segment_parser_tb.sv
`timescale 1ns / 1ps

module qr_byte_mode_segment_parser_tb;
  import qrbm_pkg::*;

  localparam int MAX_OUT = 4096;
  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SAPPEND_BITS = 16;

  // mode indicators
  localparam logic [3:0] MODE_TERMINATOR = 4'h0;
  localparam logic [3:0] MODE_NUMERIC = 4'h1;
  localparam logic [3:0] MODE_ALNUM = 4'h2;
  localparam logic [3:0] MODE_SAPPEND = 4'h3;
  localparam logic [3:0] MODE_BYTE = 4'h4;
  localparam logic [3:0] MODE_FNC1_FIRST = 4'h5;
  localparam logic [3:0] MODE_ECI = 4'h7;
  localparam logic [3:0] MODE_KANJI = 4'h8;
  localparam logic [3:0] MODE_FNC1_SECOND = 4'h9;
  localparam logic [3:0] MODE_HANZI = 4'hD;

  // indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {SEG_MODE, SEG_COUNT, SEG_DATA, SEG_SKIP} seg_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [DATA_W-1:0] in_data_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DATA_W-1:0] out_byte;
  logic [1:0] out_kind;
  logic out_is_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SYM_BYTES_W-1:0] cfg_data = '0;

  qr_byte_mode_segment_parser #(
    .MAX_BYTES(MAX_OUT)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_kind(out_kind),
    .out_is_last(out_is_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  logic [DATA_W-1:0] codeword_q[$];
  item_t expected_items[$];
  bit sym_bits[$];

  bit idle_en = 1'b0;
  logic in_taken = 1'b0;
  int in_gap = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int queued_total = 0;
  int codewords_in = 0;
  int n_data = 0;
  int n_ok = 0;
  int n_fail = 0;
  int cur_sb = 1;
  int cur_ver = 1;

  // parser image
  logic [SYM_BYTES_W-1:0] img_sym_bytes;
  logic [VERSION_W-1:0] img_version;
  seg_phase_t seg_phase;
  int field_left;
  logic [15:0] field_val;
  logic [15:0] chars_left;
  int sym_left;
  int byte_bits;
  int emitted;
  bit sym_done;
  bit sym_fresh;
  int step_n;

  function automatic void post_result(logic [7:0] b, logic [1:0] k, logic l);
    if (step_n < 2) begin
      expected_items.push_back('{data_byte: b, kind: k, is_last: l});
      step_n++;
    end
  endfunction

  function automatic void end_symbol(logic [1:0] k);
    post_result(8'h00, k, 1'b1);
    sym_done = 1'b1;
  endfunction

  function automatic int bits_avail();
    return byte_bits + 8 * sym_left;
  endfunction

  function automatic void begin_field(seg_phase_t ph, int len);
    seg_phase = ph;
    field_left = len;
    field_val = '0;
  endfunction

  function automatic void next_mode();
    if (bits_avail() < 4) end_symbol(KIND_OK);
    else begin_field(SEG_MODE, 4);
  endfunction

  function automatic void field_complete();
    int cbits;
    case (seg_phase)
      SEG_MODE: begin
        case (field_val[3:0])
          MODE_TERMINATOR: end_symbol(KIND_OK);
          MODE_FNC1_FIRST, MODE_FNC1_SECOND: next_mode();
          MODE_SAPPEND: begin
            if (bits_avail() < SAPPEND_BITS) end_symbol(KIND_FAIL);
            else begin_field(SEG_SKIP, SAPPEND_BITS);
          end
          MODE_BYTE: begin
            cbits = (img_version <= SHORT_COUNT_MAX_VER) ? 8 : 16;
            if (bits_avail() < cbits) end_symbol(KIND_FAIL);
            else begin_field(SEG_COUNT, cbits);
          end
          default: end_symbol(KIND_FAIL);
        endcase
      end
      SEG_COUNT: begin
        chars_left = field_val;
        if (chars_left == 0) next_mode();
        else if (int'(chars_left) * 8 > bits_avail()) end_symbol(KIND_FAIL);
        else begin_field(SEG_DATA, 8);
      end
      SEG_DATA: begin
        if (emitted < MAX_OUT) begin
          post_result(field_val[7:0], KIND_DATA, 1'b0);
          emitted++;
        end
        chars_left = chars_left - 16'd1;
        if (chars_left == 0) next_mode();
        else begin_field(SEG_DATA, 8);
      end
      default: next_mode();
    endcase
  endfunction

  function automatic void new_symbol();
    byte_bits = 0;
    begin_field(SEG_MODE, 4);
    chars_left = '0;
    emitted = 0;
    sym_done = 1'b0;
    sym_left = (img_sym_bytes == 0) ? 1 : int'(img_sym_bytes);
    sym_fresh = 1'b0;
  endfunction

  function automatic void parse_codeword(logic [7:0] b);
    step_n = 0;
    if (sym_fresh) new_symbol();
    if (sym_left > 0) sym_left--;
    if (!sym_done) begin
      byte_bits = 8;
      while (byte_bits > 0 && !sym_done) begin
        field_val = {field_val[14:0], b[byte_bits-1]};
        byte_bits--;
        if (field_left > 0) field_left--;
        if (field_left == 0) field_complete();
      end
      byte_bits = 0;
    end
    if (sym_left == 0) begin
      if (!sym_done) end_symbol(KIND_FAIL);
      sym_fresh = 1'b1;
    end
  endfunction

  // input driver: a new byte only after the previous one was transferred
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (codeword_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data_byte <= codeword_q.pop_front();
        if (idle_en && $urandom_range(0, 11) == 0) in_gap = $urandom_range(1, 17);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (idle_en && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 17);
    end
  end

  always @(posedge clk) begin
    item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SYMBOL_BYTES: img_sym_bytes = cfg_data;
          CFG_SYMBOL_VERSION: img_version = cfg_data[VERSION_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        parse_codeword(in_data_byte);
        codewords_in++;
      end
      if (out_valid && !out_stall) begin
        if (expected_items.size() == 0) begin
          $error("unexpected transfer: out_byte %0h out_kind %0d out_is_last %0d",
                 out_byte, out_kind, out_is_last);
          mismatches++;
        end else begin
          want = expected_items.pop_front();
          if (out_byte !== want.data_byte) begin
            $error("out_byte: expected %0h, got %0h", want.data_byte, out_byte);
            mismatches++;
          end
          if (out_kind !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
            mismatches++;
          end
          if (out_is_last !== want.is_last) begin
            $error("out_is_last: expected %0d, got %0d", want.is_last, out_is_last);
            mismatches++;
          end
          if (want.kind == KIND_DATA) n_data++;
          else if (want.kind == KIND_OK) n_ok++;
          else n_fail++;
        end
      end
    end
    in_taken <= rst_n && in_valid && !in_stall;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [SYM_BYTES_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_symbol_bytes(input int sb);
    cfg_write(CFG_SYMBOL_BYTES, SYM_BYTES_W'(sb));
    cur_sb = sb;
  endtask

  // upper data bits are junk the register must drop
  task automatic set_version(input int ver);
    cfg_write(CFG_SYMBOL_VERSION, {7'($urandom), VERSION_W'(ver)});
    cur_ver = ver;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (codeword_q.size() != 0 || in_valid || expected_items.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void push_bits(int unsigned v, int w);
    for (int k = w - 1; k >= 0; k--) sym_bits.push_back(bit'((v >> k) & 1));
  endfunction

  function automatic void queue_codeword(logic [7:0] b);
    codeword_q.push_back(b);
    queued_total++;
  endfunction

  // one symbol of segments; noise_pct of the segments are random modes or short byte segments
  function automatic void add_symbol(int nbytes, int max_count, int byte_pct, int noise_pct,
                                     bit cut_short);
    int total;
    int room;
    int c;
    int pick;
    int cbits;
    int keep;
    logic [7:0] b;
    total = nbytes * 8;
    cbits = (cur_ver <= int'(SHORT_COUNT_MAX_VER)) ? 8 : 16;
    sym_bits.delete();
    while (sym_bits.size() + 4 <= total) begin
      pick = $urandom_range(0, 99);
      room = (total - int'(sym_bits.size()) - 4 - cbits) / 8;
      if (pick < noise_pct) begin
        if ($urandom_range(0, 1) == 0 || room < 0) begin
          push_bits($urandom_range(0, 15), 4);
        end else begin
          push_bits(MODE_BYTE, 4);
          push_bits(room + $urandom_range(1, 6), cbits);
        end
      end else if (pick < noise_pct + byte_pct && room >= 0) begin
        c = $urandom_range(0, max_count);
        if (c > room) c = room;
        if (cbits == 8 && c > 255) c = 255;
        push_bits(MODE_BYTE, 4);
        push_bits(c, cbits);
        repeat (c) push_bits($urandom_range(0, 255), 8);
      end else if (pick < 88) begin
        push_bits(MODE_SAPPEND, 4);
        push_bits($urandom_range(0, 65535), SAPPEND_BITS);
      end else if (pick < 94) begin
        push_bits($urandom_range(0, 1) ? MODE_FNC1_FIRST : MODE_FNC1_SECOND, 4);
      end else begin
        push_bits(MODE_TERMINATOR, 4);
        break;
      end
    end
    while (sym_bits.size() < total) sym_bits.push_back(bit'($urandom_range(0, 1)));
    keep = (cut_short && nbytes > 1) ? $urandom_range(1, nbytes - 1) : nbytes;
    for (int i = 0; i < keep; i++) begin
      for (int j = 0; j < 8; j++) b = {b[6:0], sym_bits[8 * i + j]};
      queue_codeword(b);
    end
  endfunction

  initial begin
    int start;
    int nsym;
    int nb;
    int sel;
    int ver;
    img_sym_bytes = 1;
    img_version = 1;
    new_symbol();
    sym_fresh = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte symbols: terminator, invalid mode, short count, short structured append,
    // fnc1 then terminator, both fnc1 then nothing left, the failing modes
    codeword_q = {codeword_q, 8'h00, 8'hFF, 8'h40, 8'h30, 8'h50, 8'h95,
                  {MODE_NUMERIC, 4'hF}, {MODE_ALNUM, 4'hF}, {MODE_ECI, 4'hF},
                  {MODE_KANJI, 4'hF}, {MODE_HANZI, 4'hF}};
    wait_idle();

    // zero length counts as one, version zero, write to an undecoded index
    set_symbol_bytes(0);
    set_version(0);
    cfg_write(CFG_SPARE_B, 13'h1FFF);
    @(posedge clk);
    codeword_q = {codeword_q, 8'h50};
    wait_idle();

    // two data bytes and a terminator with an 8-bit count
    set_symbol_bytes(4);
    set_version(9);
    @(posedge clk);
    codeword_q = {codeword_q, 8'h40, 8'h2A, 8'hBC, 8'hD0};
    wait_idle();

    // 16-bit count, one byte, terminator, trailing byte absorbed
    set_symbol_bytes(5);
    set_version(10);
    @(posedge clk);
    codeword_q = {codeword_q, 8'h40, 8'h00, 8'h1F, 8'hF0, 8'h00};
    wait_idle();

    // byte segment longer than the data left
    set_symbol_bytes(3);
    set_version(1);
    @(posedge clk);
    codeword_q = {codeword_q, 8'h40, 8'hFF, 8'h00};
    wait_idle();

    start = queued_total;
    while (queued_total - start < RANDOM_ITEMS) begin
      idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: nb = 1;
        1: nb = 2;
        8: nb = $urandom_range(41, 160);
        9: nb = 0;
        default: nb = $urandom_range(3, 40);
      endcase
      case ($urandom_range(0, 7))
        0: ver = 0;
        1: ver = 1;
        2: ver = 9;
        3: ver = 10;
        4: ver = 40;
        5: ver = 63;
        default: ver = $urandom_range(0, 63);
      endcase
      sel = $urandom_range(0, 3);
      if (sel != 1) set_symbol_bytes(nb);
      if (sel != 2) set_version(ver);
      if (sel == 3) cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 13'($urandom));
      @(posedge clk);
      nsym = $urandom_range(1, 4);
      for (int s = 0; s < nsym; s++) begin
        nb = (cur_sb == 0) ? 1 : cur_sb;
        if ($urandom_range(0, 9) == 0) begin
          repeat (nb) queue_codeword(8'($urandom));
        end else begin
          // a symbol left unfinished makes the next register write land mid-symbol
          add_symbol(nb, 24, 70, 8, s == nsym - 1 && $urandom_range(0, 9) == 0);
        end
      end
      wait_idle();
    end

    // long symbols, back to back with no idling
    idle_en = 1'b0;
    set_symbol_bytes(120);
    set_version(40);
    @(posedge clk);
    add_symbol(120, 100, 70, 0, 1'b0);
    wait_idle();
    // byte segments only, 16-bit counts
    set_symbol_bytes(120);
    cfg_write(CFG_SYMBOL_VERSION, 13'h1FFF);
    cur_ver = 63;
    @(posedge clk);
    add_symbol(120, 100, 100, 0, 1'b0);
    wait_idle();
    repeat (20) @(posedge clk);

    $display("%0d codewords transferred over %0d cycles", codewords_in, cycle_count);
    $display("checked %0d data bytes, %0d ok ends, %0d failed ends, %0d mismatches",
             n_data, n_ok, n_fail, mismatches);
    if (mismatches == 0 && expected_items.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
